FILE: hdl/fsrs_pkg.sv
// fsrs_pkg: shared types, codes and helpers for the fabric switch route selector
// used by fsrs_route_logic, fabric_switch_route_select_core and fsrs_checker
// no dependencies
package fsrs_pkg;

    localparam int NODE_PORTS = 16;
    localparam int POOL_PORTS = 8;

    localparam logic [7:0] CREDIT_WORDS      = 8'd4;
    localparam logic [7:0] CREDIT_KIND       = 8'd2;
    localparam logic [7:0] SHORT_WRITE_WORDS = 8'd11;

    localparam logic [2:0] REG_NODE_COUNT   = 3'd0;
    localparam logic [2:0] REG_POOL_COUNT   = 3'd1;
    localparam logic [2:0] REG_POOL_ID_BASE = 3'd2;
    localparam logic [2:0] REG_REPLICATE    = 3'd3;
    localparam logic [2:0] REG_POOL_POLICY  = 3'd4;

    typedef enum logic [2:0] {
        OUT_NODE    = 3'd0,
        OUT_CREDIT  = 3'd1,
        OUT_CHOSEN  = 3'd2,
        OUT_REPL    = 3'd3,
        OUT_BLOCKED = 3'd4,
        OUT_BAD     = 3'd5
    } outcome_t;

    // first field in the highest bits, last field (dest_id) in the lowest bits
    typedef struct packed {
        logic [7:0]  pool_ready;
        logic [15:0] node_ready;
        logic [7:0]  access_word_b;
        logic [7:0]  access_word_a;
        logic [7:0]  kind_word;
        logic [7:0]  payload_words;
        logic [15:0] dest_id;
    } msg_t;

    typedef struct packed {
        logic [15:0] new_dest_id;
        logic [7:0]  pool_targets;
        logic [3:0]  node_port;
        outcome_t    outcome;
    } route_t;

    typedef struct packed {
        logic [4:0]  node_count;
        logic [4:0]  nodes;
        logic [3:0]  pools;
        logic [15:0] pool_id_base;
        logic        replicate_enable;
        logic        pool_policy;
    } route_cfg_t;

    typedef struct packed {
        logic       we;
        logic [2:0] value;
    } turn_upd_t;

    // turn modulo pool count, n is at least one when used
    function automatic logic [2:0] turn_mod(input logic [2:0] t, input logic [3:0] n);
        logic [3:0] r;
        r = {1'b0, t};
        for (int i = 0; i < 7; i++)
        begin
            if (n != 4'd0 && r >= n)
            begin
                r = r - n;
            end
        end
        return r[2:0];
    endfunction

    function automatic logic [2:0] lowest_set(input logic [7:0] v);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: hdl/fabric_switch_route_select_core.sv
// fabric_switch_route_select_core: top level of the fabric switch route selector
// depends on fsrs_pkg and fsrs_route_logic
//
// usage
//   s_axis carries one message per transfer (destination id, payload length,
//   credit and access words, node and pool ready masks); m_axis returns one
//   routing decision per message, in order
//   cfg_we/cfg_index/cfg_data write the five control registers; the user
//   must do so only while idle, the block itself does not enforce it
// pipeline
//   an accepted message is registered, decided in one pass of logic and
//   registered again; one message per cycle is taken while m_axis is not
//   stalled; the single decision stage also advances the round-robin turn register
// reset
//   rst_n clears both stages, the turn register and loads register defaults
//   (one node, one pool, pool base 100, no replication, round robin)
// stall
//   a result waiting on m_axis does not block input: the input stage still
//   takes one more message, and s_axis_tready drops only when both are full
module fabric_switch_route_select_core #(
    parameter int MAX_NODES  = 16,
    parameter int MAX_POOLS  = 8,
    parameter int WRITE_CODE = 1
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // dest_id, payload_words, kind_word, access_word_a, access_word_b,
    // node_ready, pool_ready
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // outcome, node_port, pool_targets, new_dest_id, one zero pad bit
    output logic [31:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import fsrs_pkg::*;

    localparam int NODE_CAP = (MAX_NODES < NODE_PORTS) ? MAX_NODES : NODE_PORTS;
    localparam int POOL_CAP = (MAX_POOLS < POOL_PORTS) ? MAX_POOLS : POOL_PORTS;

    logic [4:0]  node_count_reg;
    logic [3:0]  pool_count_reg;
    logic [15:0] pool_id_base_reg;
    logic        replicate_reg;
    logic        policy_reg;
    logic [2:0]  pool_turn_reg;
    logic [2:0]  pool_turn_next;
    logic        in_valid_reg;
    logic        in_valid_next;
    msg_t        in_msg_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    route_t      out_route_reg;
    route_cfg_t  rcfg;
    route_t      route;
    turn_upd_t   turn_upd;
    logic        in_take;
    logic        advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign rcfg.node_count       = node_count_reg;
    assign rcfg.nodes            = (node_count_reg > 5'(NODE_CAP)) ? 5'(NODE_CAP)
                                                                   : node_count_reg;
    assign rcfg.pools            = (pool_count_reg > 4'(POOL_CAP)) ? 4'(POOL_CAP)
                                                                   : pool_count_reg;
    assign rcfg.pool_id_base     = pool_id_base_reg;
    assign rcfg.replicate_enable = replicate_reg;
    assign rcfg.pool_policy      = policy_reg;

    fsrs_route_logic #(
        .WRITE_CODE (WRITE_CODE)
    ) u_route (
        .cfg       (rcfg),
        .msg       (in_msg_reg),
        .pool_turn (pool_turn_reg),
        .route     (route),
        .turn_upd  (turn_upd)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign pool_turn_next = (advance && turn_upd.we) ? turn_upd.value : pool_turn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pool_turn_reg <= 3'd0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            pool_turn_reg <= pool_turn_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg   <= 5'd1;
            pool_count_reg   <= 4'd1;
            pool_id_base_reg <= 16'd100;
            replicate_reg    <= 1'b0;
            policy_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NODE_COUNT:   node_count_reg   <= cfg_data[4:0];
                REG_POOL_COUNT:   pool_count_reg   <= cfg_data[3:0];
                REG_POOL_ID_BASE: pool_id_base_reg <= cfg_data;
                REG_REPLICATE:    replicate_reg    <= cfg_data[0];
                REG_POOL_POLICY:  policy_reg       <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_msg_reg <= msg_t'(s_axis_tdata);
        end
        if (advance)
        begin
            out_route_reg <= route;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_route_reg};

endmodule

FILE: hdl/fsrs_route_logic.sv
// fsrs_route_logic: routing decision for one message, pure combinational
// depends on fsrs_pkg
module fsrs_route_logic #(
    parameter int WRITE_CODE = 1
) (
    input  fsrs_pkg::route_cfg_t cfg,
    input  fsrs_pkg::msg_t       msg,
    input  logic [2:0]           pool_turn,
    output fsrs_pkg::route_t     route,
    output fsrs_pkg::turn_upd_t  turn_upd
);
    import fsrs_pkg::*;

    localparam logic [7:0] WRITE_BYTE = 8'(WRITE_CODE);

    logic        node_hit;
    logic        pool_hit;
    logic [15:0] idx;
    logic        is_credit;
    logic        is_write;
    logic [7:0]  all_mask;
    logic [7:0]  upper_mask;
    logic [7:0]  ready_mask;
    logic [7:0]  hi_mask;
    logic [2:0]  start;
    logic [2:0]  pick;
    logic [2:0]  pick_next;

    always_comb
    begin
        for (int i = 0; i < POOL_PORTS; i++)
        begin
            all_mask[i]   = 4'(i) < cfg.pools;
            upper_mask[i] = 3'(i) >= start;
        end
    end

    assign node_hit   = msg.dest_id < {11'd0, cfg.node_count};
    assign pool_hit   = msg.dest_id >= cfg.pool_id_base;
    assign idx        = msg.dest_id - cfg.pool_id_base;
    assign is_credit  = msg.payload_words == CREDIT_WORDS && msg.kind_word == CREDIT_KIND;
    assign is_write   = (msg.payload_words > SHORT_WRITE_WORDS) ?
                        (msg.access_word_b == WRITE_BYTE) :
                        (msg.payload_words == SHORT_WRITE_WORDS &&
                         msg.access_word_a == WRITE_BYTE);
    assign start      = turn_mod(pool_turn, cfg.pools);
    assign ready_mask = msg.pool_ready & all_mask;
    assign hi_mask    = ready_mask & upper_mask;
    assign pick       = (|hi_mask) ? lowest_set(hi_mask) : lowest_set(ready_mask);
    assign pick_next  = ((4'(pick) + 4'd1) == cfg.pools) ? 3'd0 : pick + 3'd1;

    always_comb
    begin
        route.outcome      = OUT_BLOCKED;
        route.node_port    = 4'd0;
        route.pool_targets = 8'd0;
        route.new_dest_id  = msg.dest_id;
        turn_upd.we        = 1'b0;
        turn_upd.value     = pick_next;
        priority if (node_hit)
        begin
            if (msg.dest_id >= {11'd0, cfg.nodes})
            begin
                route.outcome = OUT_BAD;
            end
            else if (msg.node_ready[msg.dest_id[3:0]])
            begin
                route.outcome   = OUT_NODE;
                route.node_port = msg.dest_id[3:0];
            end
        end
        else if (pool_hit)
        begin
            priority if (is_credit)
            begin
                if (idx >= {12'd0, cfg.pools})
                begin
                    route.outcome = OUT_BAD;
                end
                else if (msg.pool_ready[idx[2:0]])
                begin
                    route.outcome      = OUT_CREDIT;
                    route.pool_targets = 8'd1 << idx[2:0];
                end
            end
            else if (cfg.pools == 4'd0)
            begin
                route.outcome = OUT_BLOCKED;
            end
            else if (cfg.replicate_enable && is_write)
            begin
                if ((msg.pool_ready & all_mask) == all_mask)
                begin
                    route.outcome      = OUT_REPL;
                    route.pool_targets = all_mask;
                    route.new_dest_id  = cfg.pool_id_base;
                end
            end
            else if (cfg.pool_policy)
            begin
                if (msg.pool_ready[0])
                begin
                    route.outcome      = OUT_CHOSEN;
                    route.pool_targets = 8'd1;
                    route.new_dest_id  = cfg.pool_id_base;
                end
            end
            else if (|ready_mask)
            begin
                route.outcome      = OUT_CHOSEN;
                route.pool_targets = 8'd1 << pick;
                route.new_dest_id  = cfg.pool_id_base + 16'(pick);
                turn_upd.we        = 1'b1;
            end
        end
        else
        begin
            route.outcome = OUT_BAD;
        end
    end

endmodule

FILE: hdl/fsrs_checker.sv
// fsrs_checker: port-level assertions for fabric_switch_route_select_core
// depends on fsrs_pkg; bound to the top level at the end of this file
module fsrs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    import fsrs_pkg::*;

    logic [2:0] res_outcome;
    logic [3:0] res_port;
    logic [7:0] res_targets;

    assign res_outcome = m_axis_tdata[2:0];
    assign res_port    = m_axis_tdata[6:3];
    assign res_targets = m_axis_tdata[14:7];

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a fresh result follows a transfer on the input, through the input and output registers
    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without input transfer");

    a_port_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res_outcome != OUT_NODE |-> res_port == 4'd0)
        else $error("node port set for non-node outcome");

    a_no_targets: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (res_outcome == OUT_NODE || res_outcome == OUT_BLOCKED ||
                          res_outcome == OUT_BAD) |-> res_targets == 8'd0)
        else $error("pool targets set for non-pool outcome");

    a_one_pool: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (res_outcome == OUT_CREDIT || res_outcome == OUT_CHOSEN)
        |-> $onehot(res_targets))
        else $error("single-pool outcome without exactly one target");

endmodule

bind fabric_switch_route_select_core fsrs_checker u_fsrs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
